[rtl/websocket_frame_parser_unit_defines.svh]
// ----------------------------------------------------------------------------
// websocket frame parser assertion macros
// shared assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_PARSER_UNIT_DEFINES_SVH
`define WEBSOCKET_FRAME_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTH

// property holds at every clock edge out of reset
`define WFP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression never true at a clock edge out of reset
`define WFP_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define WFP_ASSERT(label, clk, rst_n, prop, msg)
`define WFP_ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

[rtl/wfp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfp_pkg
// types and constants shared by the websocket frame parser modules
// ----------------------------------------------------------------------------
package wfp_pkg;

  // queue depth between header parser and result stage
  localparam int unsigned QUEUE_DEPTH = 4;

  // opcodes that the parser knows
  localparam logic [3:0] OPC_TEXT   = 4'h1;
  localparam logic [3:0] OPC_BINARY = 4'h2;
  localparam logic [3:0] OPC_CLOSE  = 4'h8;

  // 7-bit length codes for the extended forms
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // header byte counts (bytes to come minus one)
  localparam logic [2:0] HCNT_EXT16 = 3'd1;
  localparam logic [2:0] HCNT_EXT64 = 3'd7;
  localparam logic [2:0] HCNT_KEY   = 3'd3;

  // result item kinds
  localparam logic ITEM_PAYLOAD = 1'b0;
  localparam logic ITEM_STATUS  = 1'b1;

  typedef enum logic [2:0] {
    PH_BYTE0   = 3'd0,
    PH_BYTE1   = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DONE    = 3'd5,
    PH_CLOSE   = 3'd6,
    PH_UNSUP   = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CLOSE = 2'd1,
    ST_UNSUP = 2'd2,
    ST_TRUNC = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [1:0]  frame_status;
    logic [3:0]  frame_opcode;
    logic [63:0] payload_length;
    logic        last_item;
  } out_item_t;

  // one classified input byte: a payload item, a status item or both
  typedef struct packed {
    logic        has_payload;
    logic [7:0]  payload_byte;
    logic        has_status;
    status_t     status;
    logic [3:0]  opcode;
    logic [63:0] length;
  } entry_t;

  // queue occupancy flags
  typedef struct packed {
    logic full;
    logic empty;
  } q_flags_t;

endpackage

[rtl/wfp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfp_front
// header parser: takes one byte a cycle when not stalled, tracks the frame
// phase, unmasks payload bytes and classifies each byte into a queue entry
// ----------------------------------------------------------------------------
`include "websocket_frame_parser_unit_defines.svh"

module wfp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  wfp_pkg::in_item_t in_data,
  input  wfp_pkg::q_flags_t q_flags,
  output logic              push,
  output wfp_pkg::entry_t   push_entry
);

  wfp_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]      opc_r, opc_nxt;
  logic            mask_r, mask_nxt;
  logic [63:0]     len_r, len_nxt;
  logic [2:0]      hcnt_r, hcnt_nxt;
  logic [31:0]     key_r, key_nxt;
  logic [63:0]     remain_r, remain_nxt;
  logic [1:0]      idx_r, idx_nxt;

  logic            accept;
  logic [7:0]      b;
  logic [7:0]      key_byte;
  logic            has_pay;
  logic [7:0]      pay_byte;
  wfp_pkg::status_t status;
  logic [63:0]     shown_len;

  assign in_stall = q_flags.full;
  assign accept   = in_valid && !q_flags.full;
  assign b        = in_data.data_byte;

  // key byte for the current payload position, first key byte first
  always_comb begin
    case (idx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // phase register and parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= wfp_pkg::PH_BYTE0;
      opc_r    <= '0;
      mask_r   <= 1'b0;
      len_r    <= '0;
      hcnt_r   <= '0;
      key_r    <= '0;
      remain_r <= '0;
      idx_r    <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      opc_r    <= opc_nxt;
      mask_r   <= mask_nxt;
      len_r    <= len_nxt;
      hcnt_r   <= hcnt_nxt;
      key_r    <= key_nxt;
      remain_r <= remain_nxt;
      idx_r    <= idx_nxt;
    end
  end

  // next phase, classification of the current byte
  always_comb begin
    phase_nxt  = phase_r;
    opc_nxt    = opc_r;
    mask_nxt   = mask_r;
    len_nxt    = len_r;
    hcnt_nxt   = hcnt_r;
    key_nxt    = key_r;
    remain_nxt = remain_r;
    idx_nxt    = idx_r;
    has_pay    = 1'b0;
    pay_byte   = b ^ (mask_r ? key_byte : 8'h00);

    unique case (phase_r)
      wfp_pkg::PH_BYTE0: begin
        opc_nxt   = b[3:0];
        phase_nxt = wfp_pkg::PH_BYTE1;
      end
      wfp_pkg::PH_BYTE1: begin
        if (opc_r == wfp_pkg::OPC_CLOSE) begin
          phase_nxt = wfp_pkg::PH_CLOSE;
        end else if (opc_r != wfp_pkg::OPC_TEXT && opc_r != wfp_pkg::OPC_BINARY) begin
          phase_nxt = wfp_pkg::PH_UNSUP;
        end else begin
          mask_nxt = b[7];
          len_nxt  = '0;
          if (b[6:0] == wfp_pkg::LEN_EXT16) begin
            phase_nxt = wfp_pkg::PH_EXTLEN;
            hcnt_nxt  = wfp_pkg::HCNT_EXT16;
          end else if (b[6:0] == wfp_pkg::LEN_EXT64) begin
            phase_nxt = wfp_pkg::PH_EXTLEN;
            hcnt_nxt  = wfp_pkg::HCNT_EXT64;
          end else begin
            len_nxt    = {57'd0, b[6:0]};
            remain_nxt = len_nxt;
            if (b[7]) begin
              phase_nxt = wfp_pkg::PH_KEY;
              hcnt_nxt  = wfp_pkg::HCNT_KEY;
            end else begin
              phase_nxt = (len_nxt == 64'd0) ? wfp_pkg::PH_DONE : wfp_pkg::PH_PAYLOAD;
            end
          end
        end
      end
      wfp_pkg::PH_EXTLEN: begin
        // big-endian length, one byte a cycle while not stalled
        len_nxt = {len_r[55:0], b};
        if (hcnt_r == 3'd0) begin
          remain_nxt = len_nxt;
          if (mask_r) begin
            phase_nxt = wfp_pkg::PH_KEY;
            hcnt_nxt  = wfp_pkg::HCNT_KEY;
          end else begin
            phase_nxt = (len_nxt == 64'd0) ? wfp_pkg::PH_DONE : wfp_pkg::PH_PAYLOAD;
          end
        end else begin
          hcnt_nxt = hcnt_r - 3'd1;
        end
      end
      wfp_pkg::PH_KEY: begin
        key_nxt = {key_r[23:0], b};
        if (hcnt_r == 3'd0) begin
          phase_nxt = (len_r == 64'd0) ? wfp_pkg::PH_DONE : wfp_pkg::PH_PAYLOAD;
        end else begin
          hcnt_nxt = hcnt_r - 3'd1;
        end
      end
      wfp_pkg::PH_PAYLOAD: begin
        // count down the bytes still owed
        has_pay    = 1'b1;
        idx_nxt    = idx_r + 2'd1;
        remain_nxt = remain_r - 64'd1;
        if (remain_r == 64'd1) begin
          phase_nxt = wfp_pkg::PH_DONE;
        end
      end
      wfp_pkg::PH_DONE,
      wfp_pkg::PH_CLOSE,
      wfp_pkg::PH_UNSUP: begin
        // trailing bytes ignored
      end
      default: begin
      end
    endcase

    // status as seen after this byte
    unique case (phase_nxt)
      wfp_pkg::PH_DONE:  status = wfp_pkg::ST_OK;
      wfp_pkg::PH_CLOSE: status = wfp_pkg::ST_CLOSE;
      wfp_pkg::PH_UNSUP: status = wfp_pkg::ST_UNSUP;
      default:           status = wfp_pkg::ST_TRUNC;
    endcase

    if (phase_nxt == wfp_pkg::PH_KEY || phase_nxt == wfp_pkg::PH_PAYLOAD ||
        phase_nxt == wfp_pkg::PH_DONE) begin
      shown_len = len_nxt;
    end else begin
      shown_len = 64'd0;
    end

    // entry for the queue
    push_entry.has_payload  = has_pay;
    push_entry.payload_byte = pay_byte;
    push_entry.has_status   = in_data.end_of_buffer;
    push_entry.status       = status;
    push_entry.opcode       = opc_nxt;
    push_entry.length       = shown_len;

    // end of buffer returns the parser to its reset state
    if (in_data.end_of_buffer) begin
      phase_nxt  = wfp_pkg::PH_BYTE0;
      opc_nxt    = '0;
      mask_nxt   = 1'b0;
      len_nxt    = '0;
      hcnt_nxt   = '0;
      key_nxt    = '0;
      remain_nxt = '0;
      idx_nxt    = '0;
    end
  end

  assign push = accept && (has_pay || in_data.end_of_buffer);

  `WFP_ASSERT(a_eob_restarts, clk, rst_n, accept && in_data.end_of_buffer |=> phase_r == wfp_pkg::PH_BYTE0, "parser did not restart after end of buffer")
  `WFP_ASSERT(a_payload_owed, clk, rst_n, phase_r == wfp_pkg::PH_PAYLOAD |-> remain_r != 64'd0, "payload phase with no bytes owed")
  `WFP_ASSERT_NEVER(a_no_push_full, clk, rst_n, push && q_flags.full, "push into a full queue")

endmodule

[rtl/wfp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfp_queue
// short first-in first-out queue of classified items between parser and
// result stage
// ----------------------------------------------------------------------------
`include "websocket_frame_parser_unit_defines.svh"

module wfp_queue #(
  parameter int unsigned DEPTH = wfp_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wfp_pkg::entry_t   push_entry,
  input  logic              pop,
  output wfp_pkg::entry_t   head_entry,
  output wfp_pkg::q_flags_t q_flags
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  wfp_pkg::entry_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  // pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign head_entry    = mem[rd_ptr_r];
  assign q_flags.full  = (count_r == FULL_CNT);
  assign q_flags.empty = (count_r == '0);

  `WFP_ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && q_flags.empty, "pop from an empty queue")
  `WFP_ASSERT(a_count_bound, clk, rst_n, count_r <= FULL_CNT, "queue count beyond depth")
  `WFP_ASSERT(a_push_fills, clk, rst_n, push && !pop |=> !q_flags.empty, "queue empty after a push")

endmodule

[rtl/wfp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfp_back
// result stage: turns queue entries into payload and status items and holds
// them in the output register until taken
// ----------------------------------------------------------------------------
`include "websocket_frame_parser_unit_defines.svh"

module wfp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  wfp_pkg::entry_t    head_entry,
  input  wfp_pkg::q_flags_t  q_flags,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output wfp_pkg::out_item_t out_data
);

  logic               out_valid_r, out_valid_nxt;
  wfp_pkg::out_item_t out_data_r, out_data_nxt;
  logic               sent_pay_r, sent_pay_nxt;
  logic               load;
  logic               take_pay;

  assign load     = !out_valid_r || !out_stall;
  assign take_pay = head_entry.has_payload && !sent_pay_r;

  // pick the next item from the head entry
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    sent_pay_nxt  = sent_pay_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = !q_flags.empty;
      if (!q_flags.empty) begin
        out_data_nxt.frame_opcode   = head_entry.opcode;
        out_data_nxt.payload_length = head_entry.length;
        if (take_pay) begin
          out_data_nxt.item_kind    = wfp_pkg::ITEM_PAYLOAD;
          out_data_nxt.payload_byte = head_entry.payload_byte;
          out_data_nxt.frame_status = wfp_pkg::ST_OK;
          out_data_nxt.last_item    = 1'b0;
        end else begin
          out_data_nxt.item_kind    = wfp_pkg::ITEM_STATUS;
          out_data_nxt.payload_byte = 8'h00;
          out_data_nxt.frame_status = head_entry.status;
          out_data_nxt.last_item    = 1'b1;
        end
        // entry done once its last item is out
        if (take_pay && head_entry.has_status) begin
          sent_pay_nxt = 1'b1;
        end else begin
          sent_pay_nxt = 1'b0;
          pop          = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sent_pay_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sent_pay_r  <= sent_pay_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `WFP_ASSERT(a_split_entry, clk, rst_n, sent_pay_r |-> !q_flags.empty && head_entry.has_status, "half-sent entry lost its status")
  `WFP_ASSERT(a_status_after_pay, clk, rst_n, load && sent_pay_r |=> out_valid_r && out_data_r.item_kind == wfp_pkg::ITEM_STATUS, "status item did not follow its payload item")
  `WFP_ASSERT(a_hold_while_stalled, clk, rst_n, out_valid_r && out_stall |=> out_valid_r && $stable(out_data_r), "stalled result item changed")

endmodule

[rtl/websocket_frame_parser_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_parser_unit
// byte-stream websocket frame header parser with payload unmasking
// ----------------------------------------------------------------------------
// Takes one byte of a received buffer per clock, the last byte marked with
// end_of_buffer, and gives the unmasked payload bytes followed by one status
// item per buffer (ok, close, unsupported opcode or truncated). A byte is
// taken every cycle while the internal queue has room; a result item passes
// through the queue storage and then the output register. The final byte of
// a buffer that still carries payload yields a payload item and a status item,
// and its entry leaves the queue (QUEUE_DEPTH entries) once both are out. On a
// truncated status the consumer discards the payload bytes of that buffer.
// ----------------------------------------------------------------------------
module websocket_frame_parser_unit #(
  parameter int unsigned QUEUE_DEPTH = wfp_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wfp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output wfp_pkg::out_item_t out_data
);

  logic              push;
  logic              pop;
  wfp_pkg::entry_t   push_entry;
  wfp_pkg::entry_t   head_entry;
  wfp_pkg::q_flags_t q_flags;

  // header parser and classifier
  wfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_flags    (q_flags),
    .push       (push),
    .push_entry (push_entry)
  );

  // decoupling queue
  wfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .q_flags    (q_flags)
  );

  // result stage
  wfp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_entry (head_entry),
    .q_flags    (q_flags),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
